// ----- rtl/range_sample_conditioner_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Range sample conditioner assertion macros
// Shared concurrent assertion forms, clocked on clk_i; RSC_ASSERT is held off in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_SAMPLE_CONDITIONER_UNIT_MACROS_SVH
`define RANGE_SAMPLE_CONDITIONER_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define RSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a plain condition on every clock edge, reset included
`define RSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Range sample conditioner package
// Sequencer states, register indexes, widths, reset values and quality score constants.
// ----------------------------------------------------------------------------
package rsc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_PUSH,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    REG_MIN_RANGE    = 3'd0,
    REG_MAX_RANGE    = 3'd1,
    REG_RANGE_OFFSET = 3'd2,
    REG_WINDOW_LEN   = 3'd3,
    REG_WEAK_SIGNAL  = 3'd4,
    REG_OVERRANGE    = 3'd5
  } reg_idx_e;

  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned WINDOW_W = 4;
  localparam int unsigned QUAL_W   = 7;

  localparam logic [QUAL_W-1:0]  QUALITY_FULL    = 7'd100;
  localparam logic [QUAL_W-1:0]  PENALTY_STATUS  = 7'd30;
  localparam logic [QUAL_W-1:0]  PENALTY_SIGNAL  = 7'd20;
  localparam logic [QUAL_W-1:0]  PENALTY_AMBIENT = 7'd15;
  localparam logic [RANGE_W-1:0] AMBIENT_LIMIT   = 16'd500;

  localparam logic [RANGE_W-1:0]  MIN_RANGE_RST  = 16'd50;
  localparam logic [RANGE_W-1:0]  MAX_RANGE_RST  = 16'd2000;
  localparam logic [OFFSET_W-1:0] OFFSET_RST     = 12'd0;
  localparam logic [WINDOW_W-1:0] WINDOW_RST     = 4'd3;
  localparam logic [RANGE_W-1:0]  WEAK_RST       = 16'd13;
  localparam logic [RANGE_W-1:0]  OVERRANGE_RST  = 16'd8190;

endpackage

// ----- rtl/range_sample_conditioner_unit.sv -----
// ----------------------------------------------------------------------------
// Range sample conditioner
// Range gate, offset correction with clamp, quality score and a moving
// average over a ring of recent valid samples.
//
//   channel   dir  handshake                 payload
//   input     in   in_valid_i / in_ready_o   raw_dist_i, sensor_ok_i, meas_status_i,
//                                            echo_rate_i, ambient_level_i
//   result    out  out_valid_o / out_ready_i accepted, corrected_range,
//                                            filtered_range, sample_valid, quality
//   config    in   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Rejected, invalid or unfiltered items go from the correction state straight to
// the done state; averaged items also pass through the push state, one sum step
// per filled entry and SUM_W = 16 + clog2(MAX_WINDOW+1) restoring divide steps.
// The done state holds until the output register is free.
// The single adder is shared by the offset add, the ring sum and the divide.
// in_ready_o is high only in the idle state; a result waiting in the output
// register does not block the next input transfer.
// Reset restores register defaults and restarts the filter.
// ----------------------------------------------------------------------------
module range_sample_conditioner_unit #(
  parameter int unsigned MAX_WINDOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] raw_dist_i,
  input  logic        sensor_ok_i,
  input  logic [7:0]  meas_status_i,
  input  logic [15:0] echo_rate_i,
  input  logic [15:0] ambient_level_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [15:0] corrected_range_o,
  output logic [15:0] filtered_range_o,
  output logic        sample_valid_o,
  output logic [6:0]  quality_o
);

  localparam int unsigned RW     = rsc_pkg::RANGE_W;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W  = RW + CNT_W;
  localparam int unsigned ALU_W  = SUM_W + 1;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  rsc_pkg::state_e state_q, state_d;

  logic [RW-1:0]                min_q, max_q, weak_q, over_q;
  logic [rsc_pkg::OFFSET_W-1:0] offset_q;
  logic [rsc_pkg::WINDOW_W-1:0] window_q;

  logic [RW-1:0]     range_q, signal_q, ambient_q;
  logic              ok_q;
  logic              status_nz_q;

  logic [RW-1:0]     ring_q [MAX_WINDOW];
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;

  logic [RW-1:0]     corr_q;
  logic [6:0]        qual_q;
  logic              acc_q;
  logic              use_avg_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;

  logic              out_valid_q;
  logic              out_acc_q, out_ok_q;
  logic [RW-1:0]     out_corr_q, out_filt_q;
  logic [6:0]        out_qual_q;

  logic [ALU_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub;

  logic [CNT_W-1:0]  eff_win;
  logic              in_window;
  logic [RW-1:0]     clamp_val;
  logic [6:0]        qual_val;
  logic [SLOT_W-1:0] wr_idx;
  logic [CNT_W-1:0]  slot_next;
  logic              wrap;
  logic [CNT_W:0]    rem_shift;
  logic              out_load;
  logic              in_xfer;

  assign in_ready_o = (state_q == rsc_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == rsc_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign eff_win = (int'(window_q) > int'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                       : CNT_W'(window_q);

  assign in_window = (range_q >= min_q) && (range_q <= max_q);

  // clamp the signed sum of range and offset to 0..65535
  always_comb begin
    if (alu_res[ALU_W-1]) begin
      clamp_val = '0;
    end else if (alu_res[ALU_W-2:RW] != '0) begin
      clamp_val = '1;
    end else begin
      clamp_val = alu_res[RW-1:0];
    end
  end

  always_comb begin
    qual_val = rsc_pkg::QUALITY_FULL;
    if (status_nz_q) begin
      qual_val = qual_val - rsc_pkg::PENALTY_STATUS;
    end
    if (signal_q < weak_q) begin
      qual_val = qual_val - rsc_pkg::PENALTY_SIGNAL;
    end
    if (ambient_q > rsc_pkg::AMBIENT_LIMIT) begin
      qual_val = qual_val - rsc_pkg::PENALTY_AMBIENT;
    end
    if (!ok_q || (range_q >= over_q)) begin
      qual_val = '0;
    end
  end

  always_comb begin
    wr_idx    = (CNT_W'(slot_q) >= eff_win) ? '0 : slot_q;
    slot_next = CNT_W'(wr_idx) + CNT_W'(1);
    wrap      = (slot_next >= eff_win);
  end

  assign rem_shift = {rem_q, sum_q[SUM_W-1]};

  // shared adder
  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = rsc_pkg::ST_CORR;
        end
      end
      rsc_pkg::ST_CORR: begin
        if (in_window && ok_q && (eff_win != '0)) begin
          state_d = rsc_pkg::ST_PUSH;
        end else begin
          state_d = rsc_pkg::ST_DONE;
        end
      end
      rsc_pkg::ST_PUSH: begin
        state_d = rsc_pkg::ST_SUM;
      end
      rsc_pkg::ST_SUM: begin
        if (idx_q + CNT_W'(1) == count_q) begin
          state_d = rsc_pkg::ST_DIV;
        end
      end
      rsc_pkg::ST_DIV: begin
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = rsc_pkg::ST_DONE;
        end
      end
      rsc_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = rsc_pkg::ST_IDLE;
        end
      end
      default: state_d = rsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      rsc_pkg::ST_CORR: begin
        alu_a = ALU_W'(range_q);
        alu_b = {{(ALU_W - rsc_pkg::OFFSET_W){offset_q[rsc_pkg::OFFSET_W-1]}}, offset_q};
      end
      rsc_pkg::ST_SUM: begin
        alu_a = ALU_W'(sum_q);
        alu_b = ALU_W'(ring_q[idx_q[SLOT_W-1:0]]);
      end
      rsc_pkg::ST_DIV: begin
        alu_a   = ALU_W'(rem_shift);
        alu_b   = ALU_W'(count_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rsc_pkg::ST_IDLE;
      min_q    <= rsc_pkg::MIN_RANGE_RST;
      max_q    <= rsc_pkg::MAX_RANGE_RST;
      offset_q <= rsc_pkg::OFFSET_RST;
      window_q <= rsc_pkg::WINDOW_RST;
      weak_q   <= rsc_pkg::WEAK_RST;
      over_q   <= rsc_pkg::OVERRANGE_RST;
      slot_q   <= '0;
      full_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rsc_pkg::REG_MIN_RANGE:    min_q    <= cfg_wdata_i;
          rsc_pkg::REG_MAX_RANGE:    max_q    <= cfg_wdata_i;
          rsc_pkg::REG_RANGE_OFFSET: offset_q <= cfg_wdata_i[rsc_pkg::OFFSET_W-1:0];
          rsc_pkg::REG_WINDOW_LEN: begin
            window_q <= cfg_wdata_i[rsc_pkg::WINDOW_W-1:0];
            slot_q   <= '0;
            full_q   <= 1'b0;
          end
          rsc_pkg::REG_WEAK_SIGNAL:  weak_q   <= cfg_wdata_i;
          rsc_pkg::REG_OVERRANGE:    over_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == rsc_pkg::ST_PUSH) begin
        slot_q <= wrap ? '0 : slot_next[SLOT_W-1:0];
        if (wrap) begin
          full_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      range_q     <= raw_dist_i;
      ok_q        <= sensor_ok_i;
      status_nz_q <= (meas_status_i != '0);
      signal_q    <= echo_rate_i;
      ambient_q   <= ambient_level_i;
    end
    unique case (state_q)
      rsc_pkg::ST_CORR: begin
        acc_q     <= in_window;
        corr_q    <= in_window ? clamp_val : '0;
        qual_q    <= in_window ? qual_val : '0;
        ok_q      <= ok_q && in_window;
        use_avg_q <= in_window && ok_q && (eff_win != '0);
      end
      rsc_pkg::ST_PUSH: begin
        ring_q[wr_idx] <= corr_q;
        count_q        <= (wrap || full_q) ? eff_win : slot_next;
        idx_q          <= '0;
        sum_q          <= '0;
      end
      rsc_pkg::ST_SUM: begin
        sum_q  <= alu_res[SUM_W-1:0];
        idx_q  <= idx_q + CNT_W'(1);
        rem_q  <= '0;
        step_q <= '0;
      end
      rsc_pkg::ST_DIV: begin
        if (!alu_res[ALU_W-1]) begin
          rem_q <= alu_res[CNT_W-1:0];
        end else begin
          rem_q <= rem_shift[CNT_W-1:0];
        end
        sum_q  <= {sum_q[SUM_W-2:0], !alu_res[ALU_W-1]};
        step_q <= step_q + STEP_W'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_acc_q  <= acc_q;
      out_ok_q   <= ok_q;
      out_corr_q <= corr_q;
      out_filt_q <= use_avg_q ? sum_q[RW-1:0] : corr_q;
      out_qual_q <= qual_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign corrected_range_o = out_corr_q;
  assign filtered_range_o  = out_filt_q;
  assign sample_valid_o    = out_ok_q;
  assign quality_o         = out_qual_q;

`include "range_sample_conditioner_unit_macros.svh"

  `RSC_ASSERT(a_xfer_starts_corr, in_xfer |=> (state_q == rsc_pkg::ST_CORR), "transfer did not start sequencer")
  `RSC_ASSERT(a_slot_in_ring, int'(slot_q) < int'(MAX_WINDOW), "write slot beyond ring")
  `RSC_ASSERT(a_div_count_nonzero, (state_q == rsc_pkg::ST_DIV) |-> (count_q != '0), "divide by zero count")
  `RSC_ASSERT(a_reject_zero, (out_valid_o && !accepted_o) |-> (corrected_range_o == '0 && filtered_range_o == '0 && quality_o == '0 && !sample_valid_o), "rejected result not cleared")
  `RSC_ASSERT(a_quality_max, out_valid_o |-> (quality_o <= rsc_pkg::QUALITY_FULL), "quality above full score")

endmodule

// ----- tb/tb_range_sample_conditioner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sample conditioner testbench
// Drives distance samples through the valid/ready input channel under random
// bursts and gaps, stalls the result channel on its own pattern, and checks
// every result against an in-bench model of the range gate, offset clamp,
// moving average ring and quality score. Register settings change between
// phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module tb_range_sample_conditioner_unit;

  localparam int unsigned WIN_LIMIT         = 10;
  localparam int unsigned SCORE_START       = 100;
  localparam int unsigned STATUS_COST       = 30;
  localparam int unsigned WEAK_COST         = 20;
  localparam int unsigned AMBIENT_COST      = 15;
  localparam int unsigned AMBIENT_CEILING   = 500;
  localparam int unsigned REPORT_LIMIT      = 10;
  localparam int unsigned STALL_LIMIT       = 3000;
  localparam int unsigned DRAIN_TAIL        = 64;
  localparam int unsigned HOLD_CYCLES       = 400;
  localparam int unsigned PRESSURE_AT       = 400;
  localparam int unsigned NUM_SETTINGS      = 8;
  localparam int unsigned ITEMS_PER_SETTING = 125;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [15:0] raw_dist;
    logic        sensor_ok;
    logic [7:0]  meas_status;
    logic [15:0] echo_rate;
    logic [15:0] ambient_level;
  } range_sample_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] corrected_range;
    logic [15:0] filtered_range;
    logic        sample_valid;
    logic [6:0]  quality;
  } conditioned_t;

  typedef struct {
    logic [2:0]  idx;
    logic [15:0] data;
  } reg_write_t;

  class range_scoreboard;
    logic [15:0]        min_mm;
    logic [15:0]        max_mm;
    logic signed [11:0] offset_mm;
    logic [3:0]         window;
    logic [15:0]        weak_level;
    logic [15:0]        over_level;
    logic [15:0]        ring [WIN_LIMIT];
    int unsigned        slot;
    bit                 full;
    conditioned_t       awaited [$];
    int unsigned        mismatches;
    int unsigned        samples_seen;

    function new();
      min_mm       = 16'd50;
      max_mm       = 16'd2000;
      offset_mm    = 12'sd0;
      window       = 4'd3;
      weak_level   = 16'd13;
      over_level   = 16'd8190;
      mismatches   = 0;
      samples_seen = 0;
      restart_filter();
    endfunction

    function void restart_filter();
      slot = 0;
      full = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        rsc_pkg::REG_MIN_RANGE:    min_mm = data;
        rsc_pkg::REG_MAX_RANGE:    max_mm = data;
        rsc_pkg::REG_RANGE_OFFSET: offset_mm = data[11:0];
        rsc_pkg::REG_WINDOW_LEN: begin
          window = data[3:0];
          restart_filter();
        end
        rsc_pkg::REG_WEAK_SIGNAL:  weak_level = data;
        rsc_pkg::REG_OVERRANGE:    over_level = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] push_and_average(logic [15:0] value);
      int unsigned w;
      int unsigned count;
      int unsigned sum;
      int unsigned i;
      w = (window > WIN_LIMIT) ? WIN_LIMIT : int'(window);
      if (w == 0) return value;
      if (slot >= w) slot = 0;
      ring[slot] = value;
      slot++;
      if (slot >= w) begin
        slot = 0;
        full = 1'b1;
      end
      count = full ? w : slot;
      sum = 0;
      for (i = 0; i < count; i++) sum += ring[i];
      return 16'(sum / count);
    endfunction

    function logic [6:0] score_quality(range_sample_t s);
      int score;
      if (!s.sensor_ok) return 7'd0;
      score = SCORE_START;
      if (s.meas_status != 8'd0) score -= STATUS_COST;
      if (s.echo_rate < weak_level) score -= WEAK_COST;
      if (s.ambient_level > AMBIENT_CEILING) score -= AMBIENT_COST;
      if (s.raw_dist >= over_level) score = 0;
      return 7'(score);
    endfunction

    function void note_sample(range_sample_t s);
      conditioned_t c;
      int corr;
      samples_seen++;
      c = '0;
      if (s.raw_dist >= min_mm && s.raw_dist <= max_mm) begin
        corr = int'(s.raw_dist) + int'(offset_mm);
        if (corr < 0) corr = 0;
        if (corr > 65535) corr = 65535;
        c.accepted        = 1'b1;
        c.corrected_range = 16'(corr);
        c.filtered_range  = s.sensor_ok ? push_and_average(16'(corr)) : 16'(corr);
        c.sample_valid    = s.sensor_ok;
        c.quality         = score_quality(s);
      end
      awaited.push_back(c);
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(conditioned_t got);
      conditioned_t want;
      if (awaited.size() == 0) begin
        flag("unexpected result filtered_range", 0, got.filtered_range);
        return;
      end
      want = awaited.pop_front();
      if (got.accepted !== want.accepted) flag("accepted", want.accepted, got.accepted);
      if (got.corrected_range !== want.corrected_range)
        flag("corrected_range", want.corrected_range, got.corrected_range);
      if (got.filtered_range !== want.filtered_range)
        flag("filtered_range", want.filtered_range, got.filtered_range);
      if (got.sample_valid !== want.sample_valid)
        flag("sample_valid", want.sample_valid, got.sample_valid);
      if (got.quality !== want.quality) flag("quality", want.quality, got.quality);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = 3'd0;
  logic [15:0] cfg_wdata_i     = 16'd0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [15:0] raw_dist_i      = 16'd0;
  logic        sensor_ok_i     = 1'b0;
  logic [7:0]  meas_status_i   = 8'd0;
  logic [15:0] echo_rate_i     = 16'd0;
  logic [15:0] ambient_level_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        accepted_o;
  logic [15:0] corrected_range_o;
  logic [15:0] filtered_range_o;
  logic        sample_valid_o;
  logic [6:0]  quality_o;

  range_scoreboard sb = new();
  reg_write_t      reg_writes [$];
  int unsigned     burst_left = 0;
  int unsigned     hold_left  = 0;
  int unsigned     mode_left  = 0;
  int unsigned     ready_mode = 0;
  bit              pressure_done = 1'b0;

  range_sample_conditioner_unit #(
    .MAX_WINDOW(WIN_LIMIT)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_dist_i       (raw_dist_i),
    .sensor_ok_i      (sensor_ok_i),
    .meas_status_i    (meas_status_i),
    .echo_rate_i      (echo_rate_i),
    .ambient_level_i  (ambient_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .corrected_range_o(corrected_range_o),
    .filtered_range_o (filtered_range_o),
    .sample_valid_o   (sample_valid_o),
    .quality_o        (quality_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_sample({raw_dist_i, sensor_ok_i, meas_status_i, echo_rate_i,
                      ambient_level_i});
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({accepted_o, corrected_range_o, filtered_range_o, sample_valid_o,
                       quality_o});
  end

  // receiver: one long hold-off once, otherwise randomly chosen ready modes
  always @(posedge clk_i) begin
    if (!pressure_done && sb.samples_seen >= PRESSURE_AT) begin
      hold_left     = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(8, 80);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_range_sample_conditioner_unit: done, errors");
    $finish;
  end

  task automatic send_sample(input range_sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    {raw_dist_i, sensor_ok_i, meas_status_i, echo_rate_i, ambient_level_i} <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_fields(input logic [15:0] raw_dist, input logic ok,
                             input logic [7:0] status, input logic [15:0] signal,
                             input logic [15:0] ambient);
    send_sample({raw_dist, ok, status, signal, ambient});
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void queue_write(logic [2:0] idx, logic [15:0] data);
    reg_writes.push_back('{idx, data});
  endfunction

  task automatic apply_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= w.idx;
      cfg_wdata_i <= w.data;
      @(posedge clk_i);
      sb.write_reg(w.idx, w.data);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_setting();
    logic [15:0] lo;
    logic [15:0] hi;
    case ($urandom_range(0, 7))
      0: begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end
      1: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      default: begin
        lo = 16'($urandom_range(0, 400));
        hi = lo + 16'($urandom_range(50, 5000));
      end
    endcase
    queue_write(rsc_pkg::REG_MIN_RANGE, lo);
    queue_write(rsc_pkg::REG_MAX_RANGE, hi);
    case ($urandom_range(0, 3))
      0:       queue_write(rsc_pkg::REG_RANGE_OFFSET, 16'h0800);
      1:       queue_write(rsc_pkg::REG_RANGE_OFFSET, 16'h07FF);
      default: queue_write(rsc_pkg::REG_RANGE_OFFSET, 16'($urandom));
    endcase
    if ($urandom_range(0, 1) == 0) queue_write(rsc_pkg::REG_WINDOW_LEN, 16'($urandom));
    queue_write(rsc_pkg::REG_WEAK_SIGNAL, ($urandom_range(0, 1) == 0) ?
                16'($urandom_range(0, 300)) : 16'($urandom));
    case ($urandom_range(0, 9))
      0, 1, 2: queue_write(rsc_pkg::REG_OVERRANGE, 16'hFFFF);
      3, 4:    queue_write(rsc_pkg::REG_OVERRANGE, 16'($urandom));
      default: queue_write(rsc_pkg::REG_OVERRANGE, hi - 16'($urandom_range(0, 100)));
    endcase
  endtask

  function automatic range_sample_t random_sample();
    range_sample_t s;
    int unsigned   pick;
    pick = $urandom_range(0, 9);
    if (pick < 7 && sb.min_mm <= sb.max_mm)
      s.raw_dist = 16'($urandom_range(sb.min_mm, sb.max_mm));
    else if (pick == 8) begin
      case ($urandom_range(0, 3))
        0:       s.raw_dist = sb.min_mm - 16'd1;
        1:       s.raw_dist = sb.min_mm;
        2:       s.raw_dist = sb.max_mm;
        default: s.raw_dist = sb.max_mm + 16'd1;
      endcase
    end else if (pick == 9)
      s.raw_dist = sb.over_level + 16'($urandom_range(0, 2)) - 16'd1;
    else
      s.raw_dist = 16'($urandom);
    s.sensor_ok     = ($urandom_range(0, 7) != 0);
    s.meas_status   = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
    s.echo_rate     = ($urandom_range(0, 1) == 0) ?
                      sb.weak_level + 16'($urandom_range(0, 4)) - 16'd2 : 16'($urandom);
    s.ambient_level = ($urandom_range(0, 1) == 0) ?
                      16'(AMBIENT_CEILING - 2 + $urandom_range(0, 5)) : 16'($urandom);
    return s;
  endfunction

  initial begin : stimulus
    int unsigned k;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: gate edges, quality penalties, invalid sample, ring wrap
    send_fields(16'd49,   1'b1, 8'd0,   16'd13, 16'd500);
    send_fields(16'd50,   1'b1, 8'd0,   16'd13, 16'd500);
    send_fields(16'd2000, 1'b1, 8'hFF,  16'd12, 16'd501);
    send_fields(16'd2001, 1'b1, 8'd0,   16'd20, 16'd0);
    send_fields(16'd1000, 1'b0, 8'd0,   16'd20, 16'd0);
    send_fields(16'd1500, 1'b1, 8'd1,   16'd0,  16'hFFFF);
    send_fields(16'd700,  1'b1, 8'd0,   16'd99, 16'd100);

    // full gate, most negative offset, pass-through window, spare indexes
    drain_results();
    queue_write(rsc_pkg::REG_MIN_RANGE,    16'd0);
    queue_write(rsc_pkg::REG_MAX_RANGE,    16'hFFFF);
    queue_write(rsc_pkg::REG_RANGE_OFFSET, 16'hF800);
    queue_write(rsc_pkg::REG_WINDOW_LEN,   16'hFFF0);
    queue_write(rsc_pkg::REG_WEAK_SIGNAL,  16'hFFFF);
    queue_write(rsc_pkg::REG_OVERRANGE,    16'hFFFF);
    queue_write(REG_SPARE_A, 16'hFFFF);
    queue_write(REG_SPARE_B, 16'h0001);
    apply_writes();
    send_fields(16'd0,    1'b1, 8'd0,  16'd0,    16'd0);
    send_fields(16'hFFFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_fields(16'd2048, 1'b1, 8'd0,  16'd0,    16'd0);
    send_fields(16'h5555, 1'b0, 8'hAA, 16'h5555, 16'hAAAA);
    send_fields(16'hAAAA, 1'b1, 8'h55, 16'hAAAA, 16'h5555);

    // most positive offset with clamp, window above the ring size
    drain_results();
    queue_write(rsc_pkg::REG_RANGE_OFFSET, 16'h07FF);
    queue_write(rsc_pkg::REG_WINDOW_LEN,   16'hFFFF);
    queue_write(rsc_pkg::REG_WEAK_SIGNAL,  16'd0);
    queue_write(rsc_pkg::REG_OVERRANGE,    16'd0);
    apply_writes();
    send_fields(16'hFFFF, 1'b1, 8'd0, 16'd0, 16'd0);
    send_fields(16'd0,    1'b1, 8'd0, 16'd0, 16'd0);
    for (k = 1; k <= 9; k++) send_fields(16'(k * 6000), 1'b1, 8'd0, 16'd0, 16'd0);

    // empty gate, window rewritten with the same value
    drain_results();
    queue_write(rsc_pkg::REG_MIN_RANGE,  16'd1000);
    queue_write(rsc_pkg::REG_MAX_RANGE,  16'd999);
    queue_write(rsc_pkg::REG_WINDOW_LEN, 16'h000F);
    apply_writes();
    send_fields(16'd999,  1'b1, 8'd0, 16'd0, 16'd0);
    send_fields(16'd1000, 1'b1, 8'd0, 16'd0, 16'd0);

    // reopen the gate only: the ring is still empty after the window rewrite
    drain_results();
    queue_write(rsc_pkg::REG_MIN_RANGE, 16'd0);
    queue_write(rsc_pkg::REG_MAX_RANGE, 16'hFFFF);
    apply_writes();
    send_fields(16'd3000, 1'b1, 8'd0, 16'd0, 16'd0);
    send_fields(16'd4001, 1'b1, 8'd0, 16'd0, 16'd0);

    for (k = 0; k < NUM_SETTINGS; k++) begin
      drain_results();
      random_setting();
      apply_writes();
      for (n = 0; n < ITEMS_PER_SETTING; n++) send_sample(random_sample());
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_range_sample_conditioner_unit: done, clean");
    end else begin
      $display("tb_range_sample_conditioner_unit: done, errors");
    end
    $finish;
  end

endmodule
